FILE: hw/rtl/complex_arithmetic_unit_assert.svh
// Assertion macros for the complex arithmetic unit checker.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PORT_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SHIFT_UP  = WORD_BITS - FRAC_BITS;

    typedef logic [2:0] t_action;
    localparam t_action ACT_ADD = 3'd0;
    localparam t_action ACT_SUB = 3'd1;
    localparam t_action ACT_MUL = 3'd2;
    localparam t_action ACT_DIV = 3'd3;
    localparam t_action ACT_CMP = 3'd4;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WORD_BITS:0]   t_wsum;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [PROD_BITS:0]   t_psum;
    typedef logic [PROD_BITS-1:0]        t_mag;
    typedef logic [WORD_BITS-1:0]        t_uword;

    typedef struct packed {
        logic   ov;
        t_uword val;
    } t_sat;

    typedef struct packed {
        t_mag   rem;
        t_uword quo;
    } t_dstep;

    typedef struct packed {
        t_uword re;
        t_uword im;
        logic   eq;
        logic   dz;
        logic   ov;
        logic   is_div;
        logic   neg_re;
        logic   neg_im;
        logic   big_re;
        logic   big_im;
    } t_carry;

    // clamp sign/magnitude to the signed word range
    function automatic t_sat saturate(input logic neg, input t_mag mag);
        t_mag lim;
        t_mag m;
        t_sat s;
        lim = neg ? (t_mag'(1) << (WORD_BITS - 1))
                  : ((t_mag'(1) << (WORD_BITS - 1)) - t_mag'(1));
        s.ov = (mag > lim);
        m = s.ov ? lim : mag;
        s.val = neg ? WORD_BITS'(t_mag'(0) - m) : m[WORD_BITS-1:0];
        return s;
    endfunction

    // one restoring division step, quotient bits shift in at the bottom
    function automatic t_dstep div_step(input t_dstep s, input t_mag den);
        logic [PROD_BITS:0] trial;
        logic take;
        t_dstep n;
        trial = {s.rem, s.quo[WORD_BITS-1]};
        take = (trial >= {1'b0, den});
        n.rem = take ? PROD_BITS'(trial - {1'b0, den}) : trial[PROD_BITS-1:0];
        n.quo = {s.quo[WORD_BITS-2:0], take};
        return n;
    endfunction

    function automatic logic [PORT_BITS-1:0] to_port(input t_uword v);
        return PORT_BITS'($signed(v));
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply, divide and compare in Q16.16.
// ----------------------------------------------------------------------------
// One request per cycle enters while o_stall is low and one result per
// cycle leaves while i_stall is low; every action passes through the same
// stages, so results come out in request order. The pipe depth is set by
// the restoring divider, which resolves one quotient bit per pipeline stage
// for both the real and the imaginary part. Results are truncated toward
// zero and saturate to the signed word range with the overflow flag set;
// divide by zero returns zero with divide_by_zero set. A result held by a
// stall on the output is backed by one skid register: the pipe keeps moving
// until that register fills, then freezes and raises o_stall. o_stall is a
// register and never follows i_stall within the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_action,
    input  wire logic [31:0] i_a_re,
    input  wire logic [31:0] i_a_im,
    input  wire logic [31:0] i_b_re,
    input  wire logic [31:0] i_b_im,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_res_re,
    output logic [31:0]      o_res_im,
    output logic             o_equal,
    output logic             o_divide_by_zero,
    output logic             o_overflow
);

    // Skid register behind the output slot.
    logic        r_sk_v;
    logic [31:0] r_sk_re, r_sk_im;
    logic        r_sk_eq, r_sk_dz, r_sk_ov;

    // Global advance: the pipe moves unless the skid register is holding a
    // result behind a stalled output.
    logic en;
    logic out_free;
    assign en       = !r_sk_v;
    assign o_stall  = r_sk_v;
    assign out_free = !o_valid || !i_stall;

    // ---------------- stage 1: operand capture ----------------
    logic    r1_v;
    t_action r1_act;
    t_word   r1_ar, r1_ai, r1_br, r1_bi;

    // ---------------- stage 2: products, add/sub, compare ----------------
    logic    r2_v;
    t_action r2_act;
    t_prod   r2_prr, r2_pii, r2_pri, r2_pir, r2_pbr, r2_pbi;
    t_wsum   r2_sre, r2_sim;
    logic    r2_eq;

    t_wsum   n2_sre, n2_sim;
    always_comb begin
        if (r1_act == ACT_SUB) begin
            n2_sre = t_wsum'(r1_ar) - t_wsum'(r1_br);
            n2_sim = t_wsum'(r1_ai) - t_wsum'(r1_bi);
        end else begin
            n2_sre = t_wsum'(r1_ar) + t_wsum'(r1_br);
            n2_sim = t_wsum'(r1_ai) + t_wsum'(r1_bi);
        end
    end

    // ---------------- stage 3: product sums, |b|^2, add/sub saturate -----
    logic    r3_v;
    t_action r3_act;
    t_psum   r3_sre, r3_sim;
    t_mag    r3_den;
    t_uword  r3_are, r3_aim;
    logic    r3_aov, r3_eq;

    t_psum   n3_sre, n3_sim;
    logic    n3_nre, n3_nim;
    t_wsum   n3_mre, n3_mim;
    t_sat    n3_satre, n3_satim;
    always_comb begin
        if (r2_act == ACT_DIV) begin
            n3_sre = t_psum'(r2_prr) + t_psum'(r2_pii);
            n3_sim = t_psum'(r2_pir) - t_psum'(r2_pri);
        end else begin
            n3_sre = t_psum'(r2_prr) - t_psum'(r2_pii);
            n3_sim = t_psum'(r2_pri) + t_psum'(r2_pir);
        end
        n3_nre   = r2_sre[WORD_BITS];
        n3_nim   = r2_sim[WORD_BITS];
        n3_mre   = n3_nre ? -r2_sre : r2_sre;
        n3_mim   = n3_nim ? -r2_sim : r2_sim;
        n3_satre = saturate(n3_nre, t_mag'($unsigned(n3_mre)));
        n3_satim = saturate(n3_nim, t_mag'($unsigned(n3_mim)));
    end

    // ---------------- stage 4: sign / magnitude ----------------
    logic    r4_v;
    t_action r4_act;
    logic    r4_nre, r4_nim;
    t_mag    r4_mre, r4_mim;
    t_mag    r4_den;
    t_uword  r4_are, r4_aim;
    logic    r4_aov, r4_eq;

    logic    n4_nre, n4_nim;
    t_psum   n4_fre, n4_fim;
    always_comb begin
        n4_nre = r3_sre[PROD_BITS];
        n4_nim = r3_sim[PROD_BITS];
        n4_fre = n4_nre ? -r3_sre : r3_sre;
        n4_fim = n4_nim ? -r3_sim : r3_sim;
    end

    // ---------------- stage 5: non-divide results, divider setup --------
    logic    r5_v;
    t_carry  r5_c;
    t_dstep  r5_dre, r5_dim;
    t_mag    r5_den;

    t_carry  n5_c;
    t_dstep  n5_dre, n5_dim;
    t_sat    n5_mre, n5_mim;
    t_mag    n5_lre, n5_lim;
    logic [PROD_BITS+SHIFT_UP-1:0] n5_lim_den;
    always_comb begin
        n5_mre     = saturate(r4_nre, r4_mre >> FRAC_BITS);
        n5_mim     = saturate(r4_nim, r4_mim >> FRAC_BITS);
        n5_lim_den = (PROD_BITS + SHIFT_UP)'(r4_den) << SHIFT_UP;
        n5_c        = '0;
        n5_c.neg_re = r4_nre;
        n5_c.neg_im = r4_nim;
        // quotient at or above 2^WORD_BITS saturates for sure
        n5_c.big_re = ((PROD_BITS + SHIFT_UP)'(r4_mre) >= n5_lim_den);
        n5_c.big_im = ((PROD_BITS + SHIFT_UP)'(r4_mim) >= n5_lim_den);
        case (r4_act)
            ACT_ADD, ACT_SUB: begin
                n5_c.re = r4_are;
                n5_c.im = r4_aim;
                n5_c.ov = r4_aov;
            end
            ACT_MUL: begin
                n5_c.re = n5_mre.val;
                n5_c.im = n5_mim.val;
                n5_c.ov = n5_mre.ov | n5_mim.ov;
            end
            ACT_DIV: begin
                n5_c.is_div = 1'b1;
                n5_c.dz     = (r4_den == '0);
            end
            ACT_CMP: begin
                n5_c.eq = r4_eq;
            end
            default: begin
            end
        endcase
        // dividend is mag * 2^FRAC_BITS; bits above the low word seed the remainder
        n5_lre     = r4_mre << FRAC_BITS;
        n5_lim     = r4_mim << FRAC_BITS;
        n5_dre.rem = r4_mre >> SHIFT_UP;
        n5_dre.quo = n5_lre[WORD_BITS-1:0];
        n5_dim.rem = r4_mim >> SHIFT_UP;
        n5_dim.quo = n5_lim[WORD_BITS-1:0];
    end

    // ---------------- divider stages ----------------
    logic   r_dv_v   [WORD_BITS];
    t_carry r_dv_c   [WORD_BITS];
    t_dstep r_dv_re  [WORD_BITS];
    t_dstep r_dv_im  [WORD_BITS];
    t_mag   r_dv_den [WORD_BITS];

    // ---------------- output stage ----------------
    t_carry c_last;
    t_sat   n_o_re, n_o_im;
    logic [31:0] n_o_res_re, n_o_res_im;
    logic   n_o_eq, n_o_dz, n_o_ov;
    always_comb begin
        c_last = r_dv_c[WORD_BITS-1];
        n_o_re = saturate(c_last.neg_re,
                          c_last.big_re ? '1 : t_mag'(r_dv_re[WORD_BITS-1].quo));
        n_o_im = saturate(c_last.neg_im,
                          c_last.big_im ? '1 : t_mag'(r_dv_im[WORD_BITS-1].quo));
        n_o_eq = c_last.eq;
        n_o_dz = c_last.dz;
        if (c_last.is_div && !c_last.dz) begin
            n_o_res_re = to_port(n_o_re.val);
            n_o_res_im = to_port(n_o_im.val);
            n_o_ov     = n_o_re.ov | n_o_im.ov;
        end else begin
            n_o_res_re = to_port(c_last.re);
            n_o_res_im = to_port(c_last.im);
            n_o_ov     = c_last.ov;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            for (int k = 0; k < WORD_BITS; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r_dv_v[0] <= r5_v;
            for (int k = 1; k < WORD_BITS; k++) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end
    end

    // output slot and skid valid: the skid register only fills while the
    // output holds a result, and drains first once the output frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (out_free) begin
            o_valid <= r_sk_v || r_dv_v[WORD_BITS-1];
            r_sk_v  <= 1'b0;
        end else if (!r_sk_v) begin
            r_sk_v  <= r_dv_v[WORD_BITS-1];
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_sk_v) begin
                o_res_re         <= r_sk_re;
                o_res_im         <= r_sk_im;
                o_equal          <= r_sk_eq;
                o_divide_by_zero <= r_sk_dz;
                o_overflow       <= r_sk_ov;
            end else begin
                o_res_re         <= n_o_res_re;
                o_res_im         <= n_o_res_im;
                o_equal          <= n_o_eq;
                o_divide_by_zero <= n_o_dz;
                o_overflow       <= n_o_ov;
            end
        end else if (!r_sk_v) begin
            r_sk_re <= n_o_res_re;
            r_sk_im <= n_o_res_im;
            r_sk_eq <= n_o_eq;
            r_sk_dz <= n_o_dz;
            r_sk_ov <= n_o_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_act <= i_action;
            r1_ar  <= $signed(i_a_re[WORD_BITS-1:0]);
            r1_ai  <= $signed(i_a_im[WORD_BITS-1:0]);
            r1_br  <= $signed(i_b_re[WORD_BITS-1:0]);
            r1_bi  <= $signed(i_b_im[WORD_BITS-1:0]);

            r2_act <= r1_act;
            r2_prr <= t_prod'(r1_ar) * t_prod'(r1_br);
            r2_pii <= t_prod'(r1_ai) * t_prod'(r1_bi);
            r2_pri <= t_prod'(r1_ar) * t_prod'(r1_bi);
            r2_pir <= t_prod'(r1_ai) * t_prod'(r1_br);
            r2_pbr <= t_prod'(r1_br) * t_prod'(r1_br);
            r2_pbi <= t_prod'(r1_bi) * t_prod'(r1_bi);
            r2_sre <= n2_sre;
            r2_sim <= n2_sim;
            r2_eq  <= (r1_ar == r1_br) && (r1_ai == r1_bi);

            r3_act <= r2_act;
            r3_sre <= n3_sre;
            r3_sim <= n3_sim;
            r3_den <= t_mag'(r2_pbr) + t_mag'(r2_pbi);
            r3_are <= n3_satre.val;
            r3_aim <= n3_satim.val;
            r3_aov <= n3_satre.ov | n3_satim.ov;
            r3_eq  <= r2_eq;

            r4_act <= r3_act;
            r4_nre <= n4_nre;
            r4_nim <= n4_nim;
            r4_mre <= n4_fre[PROD_BITS-1:0];
            r4_mim <= n4_fim[PROD_BITS-1:0];
            r4_den <= r3_den;
            r4_are <= r3_are;
            r4_aim <= r3_aim;
            r4_aov <= r3_aov;
            r4_eq  <= r3_eq;

            r5_c   <= n5_c;
            r5_dre <= n5_dre;
            r5_dim <= n5_dim;
            r5_den <= r4_den;

            r_dv_c[0]   <= r5_c;
            r_dv_re[0]  <= div_step(r5_dre, r5_den);
            r_dv_im[0]  <= div_step(r5_dim, r5_den);
            r_dv_den[0] <= r5_den;
            for (int k = 1; k < WORD_BITS; k++) begin
                r_dv_c[k]   <= r_dv_c[k-1];
                r_dv_re[k]  <= div_step(r_dv_re[k-1], r_dv_den[k-1]);
                r_dv_im[k]  <= div_step(r_dv_im[k-1], r_dv_den[k-1]);
                r_dv_den[k] <= r_dv_den[k-1];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "complex_arithmetic_unit_assert.svh"

module cau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [2:0]  i_action,
    input wire logic [31:0] i_a_re,
    input wire logic [31:0] i_a_im,
    input wire logic [31:0] i_b_re,
    input wire logic [31:0] i_b_im,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_res_re,
    input wire logic [31:0] o_res_im,
    input wire logic        o_equal,
    input wire logic        o_divide_by_zero,
    input wire logic        o_overflow
);

    // held result stays put
    `CAU_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_res_re) && $stable(o_res_im) && $stable(o_overflow), "stalled result changed")

    // empty output slot never back-pressures the request side
    `CAU_ASSERT_NOW(a_no_stall, !o_valid, !o_stall, "stall with empty output")

    // divide by zero gives a clean zero result
    `CAU_ASSERT_NOW(a_dz_zero, o_valid && o_divide_by_zero, o_res_re == 32'd0 && o_res_im == 32'd0 && !o_overflow && !o_equal, "bad divide-by-zero result")

    // compare result carries only the equal flag
    `CAU_ASSERT_NOW(a_eq_only, o_valid && o_equal, o_res_re == 32'd0 && o_res_im == 32'd0 && !o_overflow, "bad compare result")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the complex arithmetic unit: directed corner
// requests, random traffic under bursty input and output stalls, and a long
// output hold-off. Every result is checked against an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import cau_pkg::*;

    localparam int  LATENCY    = WORD_BITS + 6;
    localparam int  CYCLE_CAP  = 400000;
    localparam int  RAND_ITEMS = 1300;
    localparam logic [2:0] ACT_BAD5 = 3'd5;
    localparam logic [2:0] ACT_BAD6 = 3'd6;
    localparam logic [2:0] ACT_BAD7 = 3'd7;
    localparam logic [31:0] W_MAX  = 32'h7fffffff;
    localparam logic [31:0] W_MIN  = 32'h80000000;
    localparam logic [31:0] W_ONE  = 32'h00010000;
    localparam logic [31:0] W_NONE = 32'hffff0000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        dz;
        logic        ov;
    } t_cplx_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [31:0] i_a_re;
    logic [31:0] i_a_im;
    logic [31:0] i_b_re;
    logic [31:0] i_b_im;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_res_re;
    logic [31:0] o_res_im;
    logic        o_equal;
    logic        o_divide_by_zero;
    logic        o_overflow;

    t_cplx_result pending_results[$];
    int           err_count;
    int           cycle_count;
    int           stall_pct;     // receiver stall probability, percent
    int           hold_cycles;   // forced receiver hold-off remaining

    complex_arithmetic_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_a_re           (i_a_re),
        .i_a_im           (i_a_im),
        .i_b_re           (i_b_re),
        .i_b_im           (i_b_im),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_res_re         (o_res_re),
        .o_res_im         (o_res_im),
        .o_equal          (o_equal),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflow       (o_overflow)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // clamp a sign/magnitude value into the signed 32-bit range
    function automatic logic [31:0] clamp_word(input logic neg, input logic [127:0] mag,
                                               inout logic ov);
        logic [127:0] lim;
        logic [127:0] m;
        lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
        m = mag;
        if (m > lim) begin
            m  = lim;
            ov = 1'b1;
        end
        return neg ? 32'(128'd0 - m) : m[31:0];
    endfunction

    function automatic logic [127:0] abs_wide(input logic signed [127:0] v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic t_cplx_result compute_result(input logic [2:0] act,
                                                    input logic [31:0] ar_w,
                                                    input logic [31:0] ai_w,
                                                    input logic [31:0] br_w,
                                                    input logic [31:0] bi_w);
        logic signed [127:0] ar, ai, br, bi, v;
        logic [127:0]        den;
        t_cplx_result        r;
        logic                ov;
        ar = $signed(ar_w);
        ai = $signed(ai_w);
        br = $signed(br_w);
        bi = $signed(bi_w);
        r  = '0;
        ov = 1'b0;
        case (act)
            ACT_ADD: begin
                v = ar + br;
                r.re = clamp_word(v < 0, abs_wide(v), ov);
                v = ai + bi;
                r.im = clamp_word(v < 0, abs_wide(v), ov);
            end
            ACT_SUB: begin
                v = ar - br;
                r.re = clamp_word(v < 0, abs_wide(v), ov);
                v = ai - bi;
                r.im = clamp_word(v < 0, abs_wide(v), ov);
            end
            ACT_MUL: begin
                // exact sum first, then truncate the magnitude
                v = ar * br - ai * bi;
                r.re = clamp_word(v < 0, abs_wide(v) >> FRAC_BITS, ov);
                v = ar * bi + ai * br;
                r.im = clamp_word(v < 0, abs_wide(v) >> FRAC_BITS, ov);
            end
            ACT_DIV: begin
                den = 128'(br * br + bi * bi);
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    v = ar * br + ai * bi;
                    r.re = clamp_word(v < 0, (abs_wide(v) << FRAC_BITS) / den, ov);
                    v = ai * br - ar * bi;
                    r.im = clamp_word(v < 0, (abs_wide(v) << FRAC_BITS) / den, ov);
                end
            end
            ACT_CMP: r.eq = (ar == br) && (ai == bi);
            default: ;
        endcase
        r.ov = ov;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [2:0] act, input logic [31:0] ar,
                                input logic [31:0] ai, input logic [31:0] br,
                                input logic [31:0] bi);
        i_valid  = 1'b1;
        i_action = act;
        i_a_re   = ar;
        i_a_im   = ai;
        i_b_re   = br;
        i_b_im   = bi;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        pending_results.push_back(compute_result(act, ar, ai, br, bi));
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(input int n);
        i_valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // operand mix: full random, small, zero, extremes, small integers
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0, 1:    return w;
            2, 3:    return {{12{w[19]}}, w[19:0]};
            4:       return '0;
            5:       return W_MIN;
            6:       return W_MAX;
            default: return {{12{w[3]}}, w[3:0], 16'h0};
        endcase
    endfunction

    function automatic logic [2:0] pick_action();
        if ($urandom_range(0, 19) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t timeout with %0d results pending", $time, pending_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result re=%h im=%h", $time, o_res_re, o_res_im);
                err_count++;
            end else begin
                t_cplx_result exp_r;
                exp_r = pending_results.pop_front();
                if (o_res_re !== exp_r.re) begin
                    $display("%0t res_re exp %h got %h", $time, exp_r.re, o_res_re);
                    err_count++;
                end
                if (o_res_im !== exp_r.im) begin
                    $display("%0t res_im exp %h got %h", $time, exp_r.im, o_res_im);
                    err_count++;
                end
                if (o_equal !== exp_r.eq) begin
                    $display("%0t equal exp %b got %b", $time, exp_r.eq, o_equal);
                    err_count++;
                end
                if (o_divide_by_zero !== exp_r.dz) begin
                    $display("%0t divide_by_zero exp %b got %b", $time, exp_r.dz,
                             o_divide_by_zero);
                    err_count++;
                end
                if (o_overflow !== exp_r.ov) begin
                    $display("%0t overflow exp %b got %b", $time, exp_r.ov, o_overflow);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        stall_pct = 0;
        send_request(ACT_ADD, W_MAX, W_MIN, W_MAX, W_MIN);     // both parts saturate
        send_request(ACT_ADD, W_ONE, W_NONE, W_NONE, W_ONE);   // cancels to zero
        send_request(ACT_SUB, W_MIN, W_MAX, W_ONE, W_NONE);    // saturate both ways
        send_request(ACT_SUB, W_MAX, W_MAX, W_MAX, W_MAX);
        send_request(ACT_MUL, W_MIN, W_MIN, W_MIN, W_MIN);     // huge products
        send_request(ACT_MUL, W_ONE, W_ONE, W_NONE, W_ONE);
        send_request(ACT_MUL, 32'h0000_0001, '0, W_NONE, '0);  // smallest step times minus one
        send_request(ACT_MUL, 32'hffff_ffff, 32'h0000_0003, 32'h0000_8000, 32'hffff_8000);
        send_request(ACT_DIV, W_ONE, W_ONE, '0, '0);           // divide by zero
        send_request(ACT_DIV, W_MAX, W_MIN, '0, '0);
        send_request(ACT_DIV, W_MAX, W_MAX, 32'h0000_0001, '0);// quotient saturates
        send_request(ACT_DIV, W_ONE, '0, 32'h0003_0000, '0);   // one third, truncated
        send_request(ACT_DIV, W_NONE, W_ONE, '0, 32'h0003_0000);
        send_request(ACT_DIV, W_MIN, W_MIN, W_MIN, W_MIN);
        send_request(ACT_DIV, W_MAX, W_MIN, W_MAX, W_MAX);
        send_request(ACT_CMP, W_MIN, W_MAX, W_MIN, W_MAX);     // equal
        send_request(ACT_CMP, W_MIN, W_MAX, W_MIN, W_MIN);     // imaginary differs
        send_request(ACT_CMP, '0, '0, '0, '0);
        send_request(ACT_BAD5, W_MAX, W_MAX, W_MAX, W_MAX);    // unused selectors
        send_request(ACT_BAD6, W_MIN, W_MIN, '0, '0);
        send_request(ACT_BAD7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent % 200 == 0) stall_pct = $urandom_range(0, 2) * 35;
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_request(pick_action(), pick_word(), pick_word(), pick_word(),
                             pick_word());
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        stall_pct   = 0;
        hold_cycles = 300;
        repeat (120) send_request(pick_action(), pick_word(), pick_word(), pick_word(),
                                  pick_word());
        wait_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_action    = '0;
        i_a_re      = '0;
        i_a_im      = '0;
        i_b_re      = '0;
        i_b_im      = '0;
        err_count   = 0;
        cycle_count = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_random_traffic();

        stall_pct = 0;
        repeat (2 * LATENCY) @(negedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
